/* src/stmv_pkg.sv */
package stmv_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int CFG_IDX_W  = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TTL      = 8'd3;

    localparam logic [63:0] KEY_LOW_RST  = 64'h5B7C4D1E9A3F26C8;
    localparam logic [63:0] KEY_HIGH_RST = 64'hE1A94F0DB7385C62;

    // SipHash initialisation words
    localparam logic [63:0] IV0 = 64'h736F6D6570736575;
    localparam logic [63:0] IV1 = 64'h646F72616E646F6D;
    localparam logic [63:0] IV2 = 64'h6C7967656E657261;
    localparam logic [63:0] IV3 = 64'h7465646279746573;

    localparam logic [63:0] FIN_CONST   = 64'h0000_0000_0000_00FF;
    localparam logic [31:0] TOKEN_MAGIC = 32'h43595431;
    localparam logic [7:0]  TOKEN_BYTES = 8'd24;
    localparam logic [7:0]  MSG_BYTES   = 8'd20;

    localparam logic OP_ISSUE  = 1'b0;
    localparam logic OP_VERIFY = 1'b1;

    typedef logic [3:0][63:0] sip_state_t;

    // data travelling alongside the hash state
    typedef struct packed {
        logic        verify;
        logic        pre_ok;     // length, magic and window checks
        logic [63:0] token_mac;
        logic [31:0] day;
        logic [31:0] nonce;
        logic [31:0] src;
    } token_side_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int b);
        return (x << b) | (x >> (64 - b));
    endfunction

    function automatic sip_state_t sip_round(input sip_state_t v);
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
        sip_state_t  r;
        v0 = v[0];
        v1 = v[1];
        v2 = v[2];
        v3 = v[3];
        v0 = v0 + v1; v1 = rotl(v1, 13); v1 = v1 ^ v0; v0 = rotl(v0, 32);
        v2 = v2 + v3; v3 = rotl(v3, 16); v3 = v3 ^ v2;
        v0 = v0 + v3; v3 = rotl(v3, 21); v3 = v3 ^ v0;
        v2 = v2 + v1; v1 = rotl(v1, 17); v1 = v1 ^ v2; v2 = rotl(v2, 32);
        r[0] = v0;
        r[1] = v1;
        r[2] = v2;
        r[3] = v3;
        return r;
    endfunction

endpackage

/* src/stmv_cell.sv */
module stmv_cell
    import stmv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic        prev_valid,
    input  sip_state_t  prev_v,
    input  token_side_t prev_side,
    input  logic [63:0] pre_word,   // xor into v3 before the round
    input  logic [63:0] post_word,  // xor into v0 after the round
    input  logic        post_fin,   // finalisation constant into v2
    output logic        valid,
    output sip_state_t  v,
    output token_side_t side
);

    logic        valid_reg;
    sip_state_t  v_reg;
    sip_state_t  v_next;
    token_side_t side_reg;

    always_comb
    begin
        sip_state_t pre;
        pre    = prev_v;
        pre[3] = pre[3] ^ pre_word;
        v_next = sip_round(pre);
        v_next[0] = v_next[0] ^ post_word;
        v_next[2] = v_next[2] ^ (post_fin ? FIN_CONST : 64'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && prev_valid)
        begin
            v_reg    <= v_next;
            side_reg <= prev_side;
        end
    end

    assign valid = valid_reg;
    assign v     = v_reg;
    assign side  = side_reg;

endmodule

/* src/siphash_token_mac_verify.sv */
// Channel   Handshake             Payload
// req       req_valid/req_stall   opcode issue_day nonce source_hash today
//                                 token_magic token_mac token_length
// rsp       rsp_valid/rsp_stall   mac verdict
// cfg       cfg_valid/cfg_ready   cfg_index cfg_data
//
// One item per cycle while rsp_stall is low; an accepted item passes through
// ten SipRound cells in a row, the first loaded at the accepting edge, then
// the result register, which drives rsp_valid.
// Each cell advances when it is empty or its successor advances, so bubbles
// close up; while an item waits on rsp_stall, requests enter if a cell is free.
// cfg_ready is always high. Reset clears all valid flags and restores the key.
module siphash_token_mac_verify
    import stmv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic                 opcode,
    input  logic [31:0]          issue_day,
    input  logic [31:0]          nonce,
    input  logic [31:0]          source_hash,
    input  logic [31:0]          today,
    input  logic [31:0]          token_magic,
    input  logic [63:0]          token_mac,
    input  logic [7:0]           token_length,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [63:0]          mac,
    output logic                 verdict,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    // configuration registers
    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic [31:0] version_reg;
    logic [31:0] ttl_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= KEY_LOW_RST;
            key_high_reg <= KEY_HIGH_RST;
            version_reg  <= 32'd0;
            ttl_reg      <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // writes past the last register are dropped
            if (cfg_index == REG_KEY_LOW)
            begin
                key_low_reg <= cfg_data;
            end
            if (cfg_index == REG_KEY_HIGH)
            begin
                key_high_reg <= cfg_data;
            end
            if (cfg_index == REG_VERSION)
            begin
                version_reg <= cfg_data[31:0];
            end
            if (cfg_index == REG_TTL)
            begin
                ttl_reg <= cfg_data[31:0];
            end
        end
    end

    // chain taps: index 0 is the request port, index i+1 the output of cell i
    logic        st_valid [0:NUM_ROUNDS];
    sip_state_t  st_v     [0:NUM_ROUNDS];
    token_side_t st_side  [0:NUM_ROUNDS];
    logic        take     [0:NUM_ROUNDS];

    // entry: key-dependent initial state and the checks that need no MAC
    logic [31:0] today_inc;
    logic [31:0] day_limit;
    logic        window_ok;

    always_comb
    begin
        today_inc = today + 32'd1;
        day_limit = issue_day + ttl_reg;
        window_ok = !(issue_day > today_inc) && !(today > day_limit);

        st_valid[0]          = req_valid;
        st_v[0][0]           = IV0 ^ key_low_reg;
        st_v[0][1]           = IV1 ^ key_high_reg;
        st_v[0][2]           = IV2 ^ key_low_reg;
        st_v[0][3]           = IV3 ^ key_high_reg;
        st_side[0].verify    = (opcode == OP_VERIFY);
        st_side[0].pre_ok    = (token_length == TOKEN_BYTES) &&
                               (token_magic == TOKEN_MAGIC) && window_ok;
        st_side[0].token_mac = token_mac;
        st_side[0].day       = issue_day;
        st_side[0].nonce     = nonce;
        st_side[0].src       = source_hash;
    end

    assign req_stall = !take[0];

    // cell i: message word i/2 goes in before even cells and after odd ones,
    // for the first three words; cell 5 also adds the finalisation constant
    for (genvar i = 0; i < NUM_ROUNDS; i++)
    begin : g_cell
        logic [63:0] word;
        logic [63:0] pre_word;
        logic [63:0] post_word;

        always_comb
        begin
            unique case (i / 2)
                0:       word = {st_side[i].day, TOKEN_MAGIC};
                1:       word = {st_side[i].src, st_side[i].nonce};
                default: word = {MSG_BYTES, 24'd0, version_reg};
            endcase
        end

        assign pre_word  = (i < 6 && (i % 2) == 0) ? word : 64'd0;
        assign post_word = (i < 6 && (i % 2) == 1) ? word : 64'd0;
        assign take[i]   = !st_valid[i+1] || take[i+1];

        stmv_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .take       (take[i]),
            .prev_valid (st_valid[i]),
            .prev_v     (st_v[i]),
            .prev_side  (st_side[i]),
            .pre_word   (pre_word),
            .post_word  (post_word),
            .post_fin   (i == 5),
            .valid      (st_valid[i+1]),
            .v          (st_v[i+1]),
            .side       (st_side[i+1])
        );
    end

    // result register
    logic        rsp_valid_reg;
    logic [63:0] mac_reg;
    logic        verdict_reg;
    logic [63:0] mac_next;
    logic        verdict_next;

    assign take[NUM_ROUNDS] = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        mac_next     = st_v[NUM_ROUNDS][0] ^ st_v[NUM_ROUNDS][1] ^
                       st_v[NUM_ROUNDS][2] ^ st_v[NUM_ROUNDS][3];
        verdict_next = !st_side[NUM_ROUNDS].verify ||
                       (st_side[NUM_ROUNDS].pre_ok &&
                        (st_side[NUM_ROUNDS].token_mac == mac_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (take[NUM_ROUNDS])
        begin
            rsp_valid_reg <= st_valid[NUM_ROUNDS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[NUM_ROUNDS] && st_valid[NUM_ROUNDS])
        begin
            mac_reg     <= mac_next;
            verdict_reg <= verdict_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign mac       = mac_reg;
    assign verdict   = verdict_reg;

endmodule

/* tb/sv/tb_siphash_token_mac_verify.sv */
module tb_siphash_token_mac_verify;
    import stmv_pkg::*;

    // SipHash initialisation words and token framing, kept apart from the
    // package so that the expected values do not lean on the design's copy
    localparam logic [63:0] SIP_C0    = 64'h736F6D6570736575;
    localparam logic [63:0] SIP_C1    = 64'h646F72616E646F6D;
    localparam logic [63:0] SIP_C2    = 64'h6C7967656E657261;
    localparam logic [63:0] SIP_C3    = 64'h7465646279746573;
    localparam logic [31:0] TOK_MAGIC = 32'h43595431;
    localparam logic [7:0]  TOK_LEN   = 8'd24;
    localparam logic [7:0]  MSG_LEN   = 8'd20;

    localparam int PIPE_LAT        = 10;      // extra wait once the queues are empty
    localparam int CYCLE_LIMIT     = 500000;  // slowest legal run is well under this
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 250;

    typedef struct packed {
        logic        op;
        logic [31:0] day;
        logic [31:0] nonce;
        logic [31:0] src;
        logic [31:0] today;
        logic [31:0] magic;
        logic [63:0] tmac;
        logic [7:0]  tlen;
    } tok_req_t;

    typedef struct packed {
        logic [63:0] mac;
        logic        verdict;
    } tok_rsp_t;

    typedef logic [3:0][63:0] lanes_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 req_valid    = 1'b0;
    logic                 req_stall;
    logic                 opcode       = 1'b0;
    logic [31:0]          issue_day    = '0;
    logic [31:0]          nonce        = '0;
    logic [31:0]          source_hash  = '0;
    logic [31:0]          today        = '0;
    logic [31:0]          token_magic  = '0;
    logic [63:0]          token_mac    = '0;
    logic [7:0]           token_length = '0;
    logic                 rsp_valid;
    logic                 rsp_stall    = 1'b0;
    logic [63:0]          mac;
    logic                 verdict;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [63:0]          cfg_data     = '0;

    // items waiting to be offered, and responses owed by the block in order
    tok_req_t req_q[$];
    tok_rsp_t due_q[$];

    // shadow of the configuration registers, updated on each accepted write
    logic [63:0] cur_key_lo  = 64'h5B7C4D1E9A3F26C8;
    logic [63:0] cur_key_hi  = 64'hE1A94F0DB7385C62;
    logic [31:0] cur_version = '0;
    logic [31:0] cur_ttl     = '0;

    int fail_cnt = 0;
    int cycles   = 0;
    bit req_fire = 1'b0;  // request item taken at the last rising edge
    bit gaps_on  = 1'b1;  // random idling on both sides
    int req_gap  = 0;
    int rsp_gap  = 0;

    siphash_token_mac_verify u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .issue_day    (issue_day),
        .nonce        (nonce),
        .source_hash  (source_hash),
        .today        (today),
        .token_magic  (token_magic),
        .token_mac    (token_mac),
        .token_length (token_length),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .mac          (mac),
        .verdict      (verdict),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Expected behaviour
    // ---------------------------------------------------------------

    function automatic logic [63:0] rol64(input logic [63:0] x, input int unsigned n);
        return (x << n) | (x >> (64 - n));
    endfunction

    // one SipRound over the four lanes
    function automatic lanes_t sip_mix(input lanes_t s);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        a = s[0];
        b = s[1];
        c = s[2];
        d = s[3];
        a = a + b; b = rol64(b, 13); b = b ^ a; a = rol64(a, 32);
        c = c + d; d = rol64(d, 16); d = d ^ c;
        a = a + d; d = rol64(d, 21); d = d ^ a;
        c = c + b; b = rol64(b, 17); b = b ^ c; c = rol64(c, 32);
        return {d, c, b, a};
    endfunction

    // compression: two rounds per message word
    function automatic lanes_t sip_absorb(input lanes_t s, input logic [63:0] m);
        s[3] = s[3] ^ m;
        s    = sip_mix(sip_mix(s));
        s[0] = s[0] ^ m;
        return s;
    endfunction

    // SipHash-2-4 over the 20-byte token message, little-endian words
    function automatic logic [63:0] token_tag(input logic [31:0] day,
                                              input logic [31:0] nce,
                                              input logic [31:0] src);
        lanes_t s;
        s[0] = SIP_C0 ^ cur_key_lo;
        s[1] = SIP_C1 ^ cur_key_hi;
        s[2] = SIP_C2 ^ cur_key_lo;
        s[3] = SIP_C3 ^ cur_key_hi;
        s    = sip_absorb(s, {day, TOK_MAGIC});
        s    = sip_absorb(s, {src, nce});
        s    = sip_absorb(s, {MSG_LEN, 24'd0, cur_version});  // tail word, length on top
        s[2] = s[2] ^ 64'hFF;
        repeat (4) s = sip_mix(s);
        return s[0] ^ s[1] ^ s[2] ^ s[3];
    endfunction

    // mac is always the computed one; a verify must pass all four checks
    function automatic tok_rsp_t judge_token(input tok_req_t t);
        tok_rsp_t    r;
        logic [31:0] day_cap;
        logic [31:0] day_end;
        r.mac     = token_tag(t.day, t.nonce, t.src);
        r.verdict = 1'b1;
        day_cap   = t.today + 32'd1;     // both sums wrap at 32 bits
        day_end   = t.day + cur_ttl;
        if (t.op == OP_VERIFY)
        begin
            if (t.tlen != TOK_LEN || t.magic != TOK_MAGIC || t.tmac != r.mac ||
                t.day > day_cap || t.today > day_end)
                r.verdict = 1'b0;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // well-formed token for the current key, with the given day pair
    function automatic tok_req_t verify_of(input logic [31:0] day, input logic [31:0] tdy);
        tok_req_t t;
        t.op    = OP_VERIFY;
        t.day   = day;
        t.nonce = $urandom;
        t.src   = $urandom;
        t.today = tdy;
        t.magic = TOK_MAGIC;
        t.tlen  = TOK_LEN;
        t.tmac  = token_tag(t.day, t.nonce, t.src);
        return t;
    endfunction

    function automatic tok_req_t rand_item();
        tok_req_t    t;
        logic [31:0] day;
        logic [31:0] tdy;
        int unsigned pick;
        pick = $urandom_range(0, 7);
        day  = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
        // aim most items at the edges of the validity window
        case ($urandom_range(0, 6))
            0:       tdy = day - 32'd1;            // day is today+1, just inside
            1:       tdy = day - 32'd2;            // issued in the future
            2:       tdy = day + cur_ttl;          // last valid day
            3:       tdy = day + cur_ttl + 32'd1;  // expired by a day
            4:       tdy = day + $urandom_range(0, cur_ttl);
            5:       tdy = day;
            default: tdy = $urandom;
        endcase
        t    = verify_of(day, tdy);
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            // issue, with rubbish in the fields it ignores
            t.op    = OP_ISSUE;
            t.today = $urandom;
            t.magic = $urandom;
            t.tmac  = {$urandom, $urandom};
            t.tlen  = 8'($urandom);
        end
        else if (pick < 70)
        begin
            if ($urandom_range(0, 9) == 0)
                t.tmac = t.tmac ^ (64'd1 << $urandom_range(0, 63));
        end
        else if (pick < 80)
            t.tlen = 8'($urandom_range(0, 255));
        else if (pick < 88)
            t.magic = t.magic ^ (32'd1 << $urandom_range(0, 31));
        else if (pick < 94)
            t.tmac = t.tmac ^ (64'd1 << $urandom_range(0, 63));
        else
        begin
            t.op    = 1'($urandom);
            t.today = $urandom;
            t.magic = $urandom;
            t.tmac  = {$urandom, $urandom};
            t.tlen  = 8'($urandom);
        end
        return t;
    endfunction

    // runs with the reset configuration: ttl of zero, version zero
    task automatic push_directed();
        tok_req_t t;
        tok_req_t b;
        t = '0;
        t.op = OP_ISSUE;
        req_q.push_back(t);
        t = '1;
        t.op = OP_ISSUE;
        req_q.push_back(t);
        t = '0;
        t.op = OP_VERIFY;
        req_q.push_back(t);
        t = '1;
        t.op = OP_VERIFY;
        req_q.push_back(t);
        b = verify_of(32'd100, 32'd100);
        req_q.push_back(b);
        // length off by one either way, and the length extremes
        t = b; t.tlen = 8'd23;               req_q.push_back(t);
        t = b; t.tlen = 8'd25;               req_q.push_back(t);
        t = b; t.tlen = 8'd0;                req_q.push_back(t);
        t = b; t.tlen = 8'd255;              req_q.push_back(t);
        // magic with its lowest and highest bit wrong
        t = b; t.magic = TOK_MAGIC ^ 32'h1;  req_q.push_back(t);
        t = b; t.magic = TOK_MAGIC ^ 32'h80000000; req_q.push_back(t);
        // forged MAC
        t = b; t.tmac = b.tmac ^ 64'h1;      req_q.push_back(t);
        t = b; t.tmac = b.tmac ^ {1'b1, 63'd0}; req_q.push_back(t);
        // window edges, then the wrap at the top of the day range
        req_q.push_back(verify_of(32'd101, 32'd100));
        req_q.push_back(verify_of(32'd102, 32'd100));
        req_q.push_back(verify_of(32'd100, 32'd101));
        req_q.push_back(verify_of(32'd0, 32'hFFFF_FFFF));
        req_q.push_back(verify_of(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        req_q.push_back(verify_of(32'hFFFF_FFFF, 32'd0));
        req_q.push_back(verify_of(32'd0, 32'd0));
        req_q.push_back(verify_of(32'd0, 32'hFFFF_FFFE));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // low extremes, high extremes, then random settings; the upper half of
    // the 32-bit registers' data is rubbish and must be dropped
    task automatic set_config(input int ph);
        logic [63:0] klo;
        logic [63:0] khi;
        logic [31:0] ver;
        logic [31:0] ttl;
        klo = {$urandom, $urandom};
        khi = {$urandom, $urandom};
        ver = $urandom;
        case (ph % 4)
            0:       ttl = $urandom_range(0, 3);
            1:       ttl = $urandom;
            2:       ttl = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: ttl = $urandom_range(1, 60);
        endcase
        if (ph == 1)
        begin
            klo = '0; khi = '0; ver = '0; ttl = '0;
        end
        else if (ph == 2)
        begin
            klo = '1; khi = '1; ver = '1; ttl = '1;
        end
        write_reg(REG_KEY_LOW, klo);
        write_reg(REG_KEY_HIGH, khi);
        write_reg(REG_VERSION, {$urandom, ver});
        write_reg(REG_TTL, {$urandom, ttl});
        // an index past the last register must leave everything alone
        write_reg(CFG_IDX_W'($urandom_range(4, 255)), {$urandom, $urandom});
    endtask

    // polled on rising edges, where the driver never runs
    task automatic drain_all();
        while (req_q.size() != 0 || req_valid || due_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Sequencer: reset once, then phases of items between config writes
    // ---------------------------------------------------------------
    initial
    begin : seq
        int ph;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain_all();
                set_config(ph);
            end
            // some phases run flat out; the last one has no idling at all
            gaps_on = (ph % 3 != 2) && (ph != PHASES - 1);
            if (ph == 0)
                push_directed();
            repeat (ITEMS_PER_PHASE) req_q.push_back(rand_item());
        end
        drain_all();
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver: new item or idle cycle on the falling edge, payload held
    // while stalled; receiver stall in random bursts
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : drv
        tok_req_t nxt;
        if (rst_n)
        begin
            if (!req_valid || req_fire)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_valid <= 1'b0;
                end
                else if (gaps_on && req_q.size() != 0 && $urandom_range(0, 5) == 0)
                begin
                    req_gap = $urandom_range(0, 14);
                    req_valid <= 1'b0;
                end
                else if (req_q.size() != 0)
                begin
                    nxt = req_q.pop_front();
                    req_valid    <= 1'b1;
                    opcode       <= nxt.op;
                    issue_day    <= nxt.day;
                    nonce        <= nxt.nonce;
                    source_hash  <= nxt.src;
                    today        <= nxt.today;
                    token_magic  <= nxt.magic;
                    token_mac    <= nxt.tmac;
                    token_length <= nxt.tlen;
                end
                else
                    req_valid <= 1'b0;
            end

            if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_stall <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                rsp_gap = $urandom_range(0, 14);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: on the rising edge, predict each accepted request item,
    // check each accepted response item, track config writes
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : mon
        tok_req_t seen;
        tok_rsp_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            req_fire = rst_n && req_valid && !req_stall;
            if (req_fire)
            begin
                seen.op    = opcode;
                seen.day   = issue_day;
                seen.nonce = nonce;
                seen.src   = source_hash;
                seen.today = today;
                seen.magic = token_magic;
                seen.tmac  = token_mac;
                seen.tlen  = token_length;
                due_q.push_back(judge_token(seen));
            end

            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (due_q.size() == 0)
                begin
                    $error("response item with none outstanding: mac %h verdict %b",
                           mac, verdict);
                    fail_cnt++;
                end
                else
                begin
                    want = due_q.pop_front();
                    if (mac !== want.mac)
                    begin
                        $error("mac: expected %h, actual %h", want.mac, mac);
                        fail_cnt++;
                    end
                    if (verdict !== want.verdict)
                    begin
                        $error("verdict: expected %b, actual %b", want.verdict, verdict);
                        fail_cnt++;
                    end
                end
            end

            if (rst_n && cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KEY_LOW:  cur_key_lo  = cfg_data;
                    REG_KEY_HIGH: cur_key_hi  = cfg_data;
                    REG_VERSION:  cur_version = cfg_data[31:0];
                    REG_TTL:      cur_ttl     = cfg_data[31:0];
                    default:      ;
                endcase
            end
        end
    end

endmodule
